[src/bpq_pkg.sv]
// Shared types, widths and constants of the button press qualifier.
`timescale 1ns / 1ps
package bpq_pkg;

  localparam int NUM_BUTTONS_DEF = 8;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int IDX_W     = 3;
  localparam int HOLD_W    = 13;
  localparam int REL_W     = 4;
  localparam int RPT_W     = 8;
  localparam int CODE_W    = 8;
  localparam int KIND_W    = 2;
  localparam int COUNT_W   = 5;
  localparam int INUSE_W   = 4;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;

  // Most events that one sample can queue, and how many of them wait behind the first.
  localparam int MAX_EVENTS = 4;
  localparam int PEND_SLOTS = MAX_EVENTS - 1;
  localparam int NUM_W      = $clog2(MAX_EVENTS + 1);
  localparam int PEND_W     = $clog2(PEND_SLOTS + 1);

  localparam logic [HOLD_W-1:0] HOLD_MAX = HOLD_W'(8000);

  typedef enum logic [KIND_W-1:0] {
    KIND_DOWN,
    KIND_PRESSED,
    KIND_HOLD,
    KIND_UP
  } event_kind_t;

  typedef enum logic {
    OP_SAMPLE,
    OP_POP
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUTTON_CODES,
    REG_BUTTONS_IN_USE,
    REG_DETECT_COUNT,
    REG_RELEASE_DEBOUNCE,
    REG_SHORT_LIMIT,
    REG_HOLD_LIMIT,
    REG_REPEAT_DELAY,
    REG_REPEAT_INTERVAL
  } cfg_reg_t;

  typedef struct packed {
    event_kind_t             kind;
    logic                    short_flag;
    logic [CODE_W-1:0]       code;
  } event_entry_t;

  typedef struct packed {
    logic                    pressed;
    logic [REL_W-1:0]        release_cnt;
    logic [RPT_W-1:0]        repeat_cnt;
    logic [HOLD_W-1:0]       hold_cnt;
  } button_state_t;

  localparam int ENTRY_W = $bits(event_entry_t);
  localparam int STATE_W = $bits(button_state_t);

endpackage

[src/bpq_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module bpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the entry written in the same cycle returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/button_press_qualifier_event_fifo_core.sv]
// Top level of the button press qualifier with hold, auto-repeat and event queue.
`timescale 1ns / 1ps
// The block takes one item per clock on its input stream: a button sample
// (the button index and its raw level) or a pop request, selected by tuser.
// Every item returns exactly one result item. Per-button debounce state
// (pressed flag, release debounce counter, repeat counter, hold count) lives
// in a NUM_BUTTONS-deep memory that is read when an item is accepted and
// written back when it leaves the processing stage; back-to-back samples of the
// same button are forwarded around the memory. Events go into a
// QUEUE_DEPTH-deep memory with one write port, so a sample that queues n events
// (n is at most four: down, pressed, a repeated pressed and hold) holds the
// input while its n-1 extra events are written, one per cycle; every other
// item sustains one item per cycle unless the output stalls. A pop returns
// the oldest event, or an empty result when nothing is queued; events that
// find the queue full are dropped. Per-button state reads as zero after
// reset by way of one valid flop per button, so no clearing pass is needed.
// The configuration port may be written only while no item is in flight.
module button_press_qualifier_event_fifo_core #(
  parameter int NUM_BUTTONS = bpq_pkg::NUM_BUTTONS_DEF,
  parameter int QUEUE_DEPTH = bpq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // Input stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [2:0] button_index, [3] key_level
  input  logic                           s_axis_tuser,  // [0] operation
  // Output stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [15:0]                    m_axis_tdata,  // [0] event_short, [8:1] event_code,
                                                        // [13:9] queued_count
  output logic [2:0]                     m_axis_tuser,  // [0] event_valid, [2:1] event_kind
  // Configuration write port.
  input  logic                           cfg_we,
  input  logic [bpq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpq_pkg::CFG_W-1:0]      cfg_wdata
);

  import bpq_pkg::*;

  localparam int BTN_AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int Q_AW   = $clog2(QUEUE_DEPTH);
  localparam int Q_CW   = $clog2(QUEUE_DEPTH + 1);
  localparam logic [Q_AW-1:0] Q_LAST = Q_AW'(QUEUE_DEPTH - 1);
  localparam logic [Q_CW-1:0] Q_FULL = Q_CW'(QUEUE_DEPTH);

  // Configuration registers.
  logic [CFG_W-1:0]   button_codes;
  logic [INUSE_W-1:0] buttons_in_use;
  logic [HOLD_W-1:0]  detect_count;
  logic [REL_W-1:0]   release_debounce;
  logic [HOLD_W-1:0]  short_limit;
  logic [HOLD_W-1:0]  hold_limit;
  logic [RPT_W-1:0]   repeat_delay;
  logic [RPT_W-1:0]   repeat_interval;

  always_ff @(posedge clk) begin
    if (rst) begin
      button_codes     <= '0;
      buttons_in_use   <= '0;
      detect_count     <= HOLD_W'(5);
      release_debounce <= REL_W'(4);
      short_limit      <= HOLD_W'(250);
      hold_limit       <= HOLD_W'(1500);
      repeat_delay     <= RPT_W'(250);
      repeat_interval  <= RPT_W'(50);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BUTTON_CODES:     button_codes     <= cfg_wdata;
        REG_BUTTONS_IN_USE:   buttons_in_use   <= cfg_wdata[INUSE_W-1:0];
        REG_DETECT_COUNT:     detect_count     <= cfg_wdata[HOLD_W-1:0];
        REG_RELEASE_DEBOUNCE: release_debounce <= cfg_wdata[REL_W-1:0];
        REG_SHORT_LIMIT:      short_limit      <= cfg_wdata[HOLD_W-1:0];
        REG_HOLD_LIMIT:       hold_limit       <= cfg_wdata[HOLD_W-1:0];
        REG_REPEAT_DELAY:     repeat_delay     <= cfg_wdata[RPT_W-1:0];
        REG_REPEAT_INTERVAL:  repeat_interval  <= cfg_wdata[RPT_W-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input unpacking and the processing stage.
  // ---------------------------------------------------------------------
  op_t              in_op;
  logic [IDX_W-1:0] in_index;
  logic             in_level;

  assign in_op    = op_t'(s_axis_tuser);
  assign in_index = s_axis_tdata[IDX_W-1:0];
  assign in_level = s_axis_tdata[IDX_W];

  logic             accept;
  logic             s1_valid;
  op_t              s1_op;
  logic [IDX_W-1:0] s1_index;
  logic             s1_level;
  logic             s1_fire;
  logic [PEND_W-1:0] pend_num;

  // The processing stage hands its result over once the extra events of the
  // previous sample are written and the output register is free.
  assign s1_fire       = s1_valid && (pend_num == '0) && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_fire;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op    <= in_op;
      s1_index <= in_index;
      s1_level <= in_level;
    end
  end

  // ---------------------------------------------------------------------
  // Per-button state memory with write-to-read forwarding.
  // ---------------------------------------------------------------------
  logic [BTN_AW-1:0]      st_raddr;
  logic [BTN_AW-1:0]      st_rd_addr_q;
  logic [STATE_W-1:0]     st_rdata;
  logic                   st_we;
  logic [BTN_AW-1:0]      st_waddr;
  button_state_t          st_wdata;
  logic                   st_we_q;
  logic [BTN_AW-1:0]      st_waddr_q;
  button_state_t          st_wdata_q;
  logic [NUM_BUTTONS-1:0] st_valid;
  logic                   st_valid_q;
  button_state_t          st_cur;

  // Read the entry of whichever item sits in the stage next cycle.
  assign st_raddr = accept ? BTN_AW'(in_index) : BTN_AW'(s1_index);

  bpq_ram #(
    .WIDTH (STATE_W),
    .DEPTH (NUM_BUTTONS)
  ) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= '0;
      st_we_q  <= 1'b0;
    end else begin
      st_we_q <= st_we;
      if (st_we) begin
        st_valid[st_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    st_rd_addr_q <= st_raddr;
    st_waddr_q   <= st_waddr;
    st_wdata_q   <= st_wdata;
    st_valid_q   <= (32'(st_raddr) < NUM_BUTTONS) && st_valid[st_raddr];
  end

  // A write in the cycle of the read wins over the memory's old data, and a
  // button never written since reset reads as all zero.
  always_comb begin
    if (st_we_q && (st_waddr_q == st_rd_addr_q)) begin
      st_cur = st_wdata_q;
    end else if (st_valid_q) begin
      st_cur = button_state_t'(st_rdata);
    end else begin
      st_cur = '0;
    end
  end

  // ---------------------------------------------------------------------
  // Debounce, hold and repeat logic for one sample.
  // ---------------------------------------------------------------------
  logic              sample_ok;
  logic [CODE_W-1:0] code;
  logic              qual;
  logic              pf1;
  logic [RPT_W-1:0]  rp1;
  button_state_t     nxt;
  event_entry_t      cand [MAX_EVENTS];
  logic              cand_v [MAX_EVENTS];
  event_entry_t      ev [MAX_EVENTS];
  logic [NUM_W-1:0]  ev_num;

  assign sample_ok = (s1_op == OP_SAMPLE) && ({1'b0, s1_index} < buttons_in_use)
                     && (32'(s1_index) < NUM_BUTTONS);
  assign code      = button_codes[{s1_index, 3'b000} +: CODE_W];

  always_comb begin
    qual = 1'b0;
    pf1  = st_cur.pressed;
    rp1  = st_cur.repeat_cnt;
    nxt  = st_cur;
    for (int i = 0; i < MAX_EVENTS; i++) begin
      cand[i]   = '{kind: KIND_PRESSED, short_flag: 1'b0, code: code};
      cand_v[i] = 1'b0;
    end
    cand[0].kind = KIND_DOWN;
    cand[3].kind = KIND_HOLD;

    if (s1_level) begin
      // A press qualifies on the sample whose hold count equals detect_count.
      qual            = !st_cur.pressed && (st_cur.hold_cnt == detect_count);
      pf1             = st_cur.pressed || qual;
      rp1             = qual ? repeat_delay : st_cur.repeat_cnt;
      nxt.pressed     = pf1;
      nxt.release_cnt = qual ? release_debounce : st_cur.release_cnt;
      nxt.repeat_cnt  = rp1;
      cand_v[0]       = qual;
      cand_v[1]       = qual;
      // Repeats run only under a qualified press; the qualifying sample
      // already checks with the freshly loaded delay.
      if (pf1) begin
        if (rp1 == '0) begin
          if (repeat_interval != '0) begin
            cand_v[2]      = 1'b1;
            nxt.repeat_cnt = repeat_interval;
          end
        end else begin
          nxt.repeat_cnt = rp1 - RPT_W'(1);
        end
      end
      cand_v[3] = (st_cur.hold_cnt == hold_limit);
      if (st_cur.hold_cnt < HOLD_MAX) begin
        nxt.hold_cnt = st_cur.hold_cnt + HOLD_W'(1);
      end
    end else begin
      if (st_cur.release_cnt == '0) begin
        cand[0]   = '{kind: KIND_UP, short_flag: (st_cur.hold_cnt < short_limit), code: code};
        cand_v[0] = st_cur.pressed;
        nxt       = '0;
      end else begin
        nxt.release_cnt = st_cur.release_cnt - REL_W'(1);
      end
    end
  end

  // Pack the events of this sample in queue order.
  always_comb begin
    ev_num = '0;
    for (int i = 0; i < MAX_EVENTS; i++) begin
      ev[i] = '0;
    end
    for (int i = 0; i < MAX_EVENTS; i++) begin
      if (cand_v[i]) begin
        ev[ev_num[1:0]] = cand[i];
        ev_num          = ev_num + NUM_W'(1);
      end
    end
  end

  assign st_we    = s1_fire && sample_ok;
  assign st_waddr = BTN_AW'(s1_index);
  assign st_wdata = nxt;

  // ---------------------------------------------------------------------
  // Event queue: pointers, count and the single-write event memory.
  // ---------------------------------------------------------------------
  logic [Q_AW-1:0]    wr_ptr;
  logic [Q_AW-1:0]    rd_ptr;
  logic [Q_AW-1:0]    rd_ptr_next;
  logic [Q_CW-1:0]    count;
  logic [Q_CW-1:0]    count_next;
  logic [Q_CW-1:0]    space;
  logic [NUM_W-1:0]   keep;
  logic               pop_ok;
  logic               push_now;
  event_entry_t       pend_ev [PEND_SLOTS];
  logic               fq_we;
  event_entry_t       fq_wdata;
  logic [ENTRY_W-1:0] fq_rdata;
  logic               fq_we_q;
  logic [Q_AW-1:0]    fq_waddr_q;
  event_entry_t       fq_wdata_q;
  logic [Q_AW-1:0]    fq_raddr_q;
  event_entry_t       fq_head;

  // Only the first events that fit are kept; the rest find the queue full.
  assign space    = Q_FULL - count;
  assign keep     = (32'(ev_num) < 32'(space)) ? ev_num : NUM_W'(space);
  assign push_now = s1_fire && sample_ok && (keep != '0);
  assign pop_ok   = s1_fire && (s1_op == OP_POP) && (count != '0);

  assign rd_ptr_next = !pop_ok ? rd_ptr : ((rd_ptr == Q_LAST) ? '0 : rd_ptr + Q_AW'(1));

  always_comb begin
    count_next = count;
    if (s1_fire && sample_ok) begin
      count_next = count + Q_CW'(keep);
    end else if (pop_ok) begin
      count_next = count - Q_CW'(1);
    end
  end

  // Extra events of a sample drain one per cycle ahead of anything else.
  assign fq_we    = (pend_num != '0) || push_now;
  assign fq_wdata = (pend_num != '0) ? pend_ev[0] : ev[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
      pend_num <= '0;
      fq_we_q  <= 1'b0;
    end else begin
      rd_ptr  <= rd_ptr_next;
      count   <= count_next;
      fq_we_q <= fq_we;
      if (fq_we) begin
        wr_ptr <= (wr_ptr == Q_LAST) ? '0 : wr_ptr + Q_AW'(1);
      end
      if (pend_num != '0) begin
        pend_num <= pend_num - PEND_W'(1);
      end else if (push_now) begin
        pend_num <= PEND_W'(keep - NUM_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_num != '0) begin
      for (int i = 0; i < PEND_SLOTS - 1; i++) begin
        pend_ev[i] <= pend_ev[i+1];
      end
      pend_ev[PEND_SLOTS-1] <= '0;
    end else if (push_now) begin
      for (int i = 0; i < PEND_SLOTS; i++) begin
        pend_ev[i] <= ev[i+1];
      end
    end
    fq_waddr_q <= wr_ptr;
    fq_wdata_q <= fq_wdata;
    fq_raddr_q <= rd_ptr_next;
  end

  bpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_event_ram (
    .clk   (clk),
    .we    (fq_we),
    .waddr (wr_ptr),
    .wdata (fq_wdata),
    .raddr (rd_ptr_next),
    .rdata (fq_rdata)
  );

  // The head entry may have been written in the cycle it was read.
  assign fq_head = (fq_we_q && (fq_waddr_q == fq_raddr_q)) ? fq_wdata_q
                                                            : event_entry_t'(fq_rdata);

  // ---------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------
  logic               out_event_valid;
  event_entry_t       out_entry;
  logic [COUNT_W-1:0] out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_event_valid <= pop_ok;
      out_entry       <= pop_ok ? fq_head : '0;
      out_count       <= COUNT_W'(count_next);
    end
  end

  assign m_axis_tuser = {out_entry.kind, out_event_valid};
  assign m_axis_tdata = {2'b00, out_count, out_entry.code, out_entry.short_flag};

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  logic [Q_CW:0] occ_sum;
  logic [Q_CW:0] occ_wrap;

  assign occ_sum  = (Q_CW + 1)'(rd_ptr) + (Q_CW + 1)'(count);
  assign occ_wrap = (occ_sum >= (Q_CW + 1)'(QUEUE_DEPTH)) ?
                    occ_sum - (Q_CW + 1)'(QUEUE_DEPTH) : occ_sum;

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= Q_FULL)
    else $error("event count exceeds queue depth");

  a_ptr_relation: assert property (@(posedge clk) disable iff (rst)
    (pend_num == '0) |-> (occ_wrap == (Q_CW + 1)'(wr_ptr)))
    else $error("queue pointers disagree with event count");

  a_drain_count_stable: assert property (@(posedge clk) disable iff (rst)
    (pend_num != '0) |=> $stable(count))
    else $error("event count moved while extra events drained");

  a_sample_no_event: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && (s1_op == OP_SAMPLE)) |=> !m_axis_tuser[0])
    else $error("sample item returned an event");

endmodule
